// ===== design/lfip_pkg.sv =====
// Shared types and constants for the linked free index pool.
package lfip_pkg;

    localparam int CFG_W    = 11;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CFG_W-1:0] POOL_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 11'd2047;

    localparam logic CMD_POP  = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    localparam logic REG_POOL_SIZE = 1'b0;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STATUS_OK     = 2'd0;
    localparam t_status STATUS_EMPTY  = 2'd1;
    localparam t_status STATUS_RANGE  = 2'd2;

    typedef struct packed {
        logic start;
        logic sweep;
        logic push;
        logic pop_issue;
        logic pop_empty;
        logic pop_finish;
    } t_dp_cmd;

    typedef struct packed {
        logic head_end;
        logic sweep_last;
    } t_dp_stat;

endpackage

// ===== design/lfip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lfip_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/lfip_dp.sv =====
// Datapath: pool size register, head, free count, link memory and result registers.
module lfip_dp #(
    parameter int MAX_ENTRIES = 1024,
    parameter int IDX_W       = 10,
    parameter int LINK_W      = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfip_pkg::t_dp_cmd           i_cmd,
    output lfip_pkg::t_dp_stat          o_stat,
    input  logic                        i_cfg_wr,
    input  logic [lfip_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [IDX_W-1:0]            i_index,
    output logic [lfip_pkg::CFG_W-1:0]  o_pool_size,
    output lfip_pkg::t_status           o_status,
    output logic [IDX_W-1:0]            o_granted_index,
    output logic [lfip_pkg::CNT_W-1:0]  o_free_count
);

    localparam int CMP_W = (LINK_W > lfip_pkg::CFG_W) ? LINK_W : lfip_pkg::CFG_W;
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_ENTRIES);

    logic [lfip_pkg::CFG_W-1:0] r_pool;
    logic [LINK_W-1:0]          r_head;
    logic [lfip_pkg::CNT_W-1:0] r_count;
    logic [IDX_W-1:0]           r_sweep;
    lfip_pkg::t_status          r_status;
    logic [IDX_W-1:0]           r_granted;
    logic [lfip_pkg::CNT_W-1:0] r_free;

    logic [CMP_W-1:0]           w_size_cmp;
    logic [LINK_W-1:0]          w_size;
    logic [lfip_pkg::CNT_W-1:0] w_size_cnt;
    logic                       w_in_range;
    logic [LINK_W-1:0]          w_sweep_next;
    logic [LINK_W-1:0]          w_chain;
    logic [lfip_pkg::CNT_W-1:0] w_count_inc;
    logic [lfip_pkg::CNT_W-1:0] w_count_dec;
    logic                       w_wr_en;
    logic [IDX_W-1:0]           w_wr_addr;
    logic [LINK_W-1:0]          w_wr_data;
    logic [LINK_W-1:0]          w_rd_data;

    assign w_size_cmp = (CMP_W'(r_pool) > MAX_CMP) ? MAX_CMP : CMP_W'(r_pool);
    assign w_size     = w_size_cmp[LINK_W-1:0];
    assign w_size_cnt = w_size_cmp[lfip_pkg::CNT_W-1:0];
    assign w_in_range = ({1'b0, i_index} < w_size);

    assign w_sweep_next = {1'b0, r_sweep} + LINK_W'(1);
    assign w_chain      = (w_sweep_next < w_size) ? w_sweep_next : END_MARK;

    assign w_count_inc = (r_count != lfip_pkg::COUNT_MAX) ? r_count + lfip_pkg::CNT_W'(1)
                                                          : r_count;
    assign w_count_dec = (r_count != '0) ? r_count - lfip_pkg::CNT_W'(1) : r_count;

    assign w_wr_en   = i_cmd.sweep | (i_cmd.push & w_in_range);
    assign w_wr_addr = i_cmd.sweep ? r_sweep : i_index;
    assign w_wr_data = i_cmd.sweep ? w_chain : r_head;

    lfip_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_ENTRIES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.pop_issue),
        .i_rd_addr (r_head[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= lfip_pkg::POOL_RESET;
        end else if (i_cfg_wr) begin
            r_pool <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_head  <= (w_size == '0) ? END_MARK : '0;
            r_count <= w_size_cnt;
            r_sweep <= '0;
        end
        if (i_cmd.sweep) begin
            r_sweep <= r_sweep + IDX_W'(1);
        end
        if (i_cmd.push) begin
            if (w_in_range) begin
                r_head  <= {1'b0, i_index};
                r_count <= w_count_inc;
            end
            r_status  <= w_in_range ? lfip_pkg::STATUS_OK : lfip_pkg::STATUS_RANGE;
            r_granted <= '0;
            r_free    <= w_in_range ? w_count_inc : r_count;
        end
        if (i_cmd.pop_empty) begin
            r_status  <= lfip_pkg::STATUS_EMPTY;
            r_granted <= '0;
            r_free    <= r_count;
        end
        if (i_cmd.pop_finish) begin
            r_head    <= w_rd_data;
            r_count   <= w_count_dec;
            r_status  <= lfip_pkg::STATUS_OK;
            r_granted <= r_head[IDX_W-1:0];
            r_free    <= w_count_dec;
        end
    end

    assign o_stat.head_end   = (r_head == END_MARK);
    assign o_stat.sweep_last = (r_sweep == LAST_IDX);

    assign o_pool_size     = r_pool;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_free_count    = r_free;

endmodule

// ===== design/lfip_ctrl.sv =====
// Controller: chain rebuild sweep, pop sequencing and the input/output handshakes.
module lfip_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_cmd,
    output logic                o_valid,
    input  logic                i_stall,
    input  logic                i_cfg_wr,
    output lfip_pkg::t_dp_cmd   o_cmd,
    input  lfip_pkg::t_dp_stat  i_stat
);

    typedef enum logic [1:0] {
        ST_INIT_START,
        ST_INIT,
        ST_IDLE,
        ST_POP
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_pop;
    logic   w_load;

    assign o_stall  = (r_state != ST_IDLE) | (r_out_valid & i_stall) | i_cfg_wr;
    assign w_accept = i_valid & ~o_stall;
    assign w_pop    = w_accept & (i_cmd == lfip_pkg::CMD_POP);

    always_comb begin
        o_cmd            = '0;
        o_cmd.start      = (r_state == ST_INIT_START);
        o_cmd.sweep      = (r_state == ST_INIT);
        o_cmd.push       = w_accept & (i_cmd == lfip_pkg::CMD_PUSH);
        o_cmd.pop_empty  = w_pop & i_stat.head_end;
        o_cmd.pop_issue  = w_pop & ~i_stat.head_end;
        o_cmd.pop_finish = (r_state == ST_POP);
    end

    assign w_load = o_cmd.push | o_cmd.pop_empty | o_cmd.pop_finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT_START;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr) begin
                r_state <= ST_INIT_START;
            end else begin
                case (r_state)
                    ST_INIT_START: r_state <= ST_INIT;
                    ST_INIT: begin
                        if (i_stat.sweep_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (o_cmd.pop_issue) begin
                            r_state <= ST_POP;
                        end
                    end
                    ST_POP:  r_state <= ST_IDLE;
                    default: r_state <= ST_INIT_START;
                endcase
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== design/linked_free_index_pool.sv =====
// Top level of the linked free index pool: APB register port, controller and datapath.
// Free buffer indices are kept as a linked stack in a MAX_ENTRIES-deep link memory
// with a head register and a free count. A push (cmd 1) returns its word in the cycle
// after acceptance; a pop (cmd 0) passes through the pop state because the head's link
// is read from the registered-read link memory before the new head is known; a pop from
// an empty pool answers in the cycle after acceptance. After reset and after every
// pool_size write the block rebuilds the ascending chain, one memory entry per cycle,
// and stalls input until the rebuild is done. A finished word held under output stall
// also stalls the input until it is taken.
module linked_free_index_pool #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_cmd,
    input  logic [$clog2(MAX_ENTRIES)-1:0]     i_index,
    output logic                               o_valid,
    input  logic                               i_stall,
    output lfip_pkg::t_status                  o_status,
    output logic [$clog2(MAX_ENTRIES)-1:0]     o_granted_index,
    output logic [lfip_pkg::CNT_W-1:0]         o_free_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lfip_pkg::APB_AW-1:0]        paddr,
    input  logic [lfip_pkg::APB_DW-1:0]        pwdata,
    output logic [lfip_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int LINK_W = IDX_W + 1;

    lfip_pkg::t_dp_cmd           w_cmd;
    lfip_pkg::t_dp_stat          w_stat;
    logic                        w_cfg_wr;
    logic                        w_sel_pool;
    logic [lfip_pkg::CFG_W-1:0]  w_pool_size;

    assign pready     = 1'b1;
    assign w_sel_pool = (paddr[2] == lfip_pkg::REG_POOL_SIZE);
    assign w_cfg_wr   = psel & penable & pwrite & pready & w_sel_pool;
    assign prdata     = w_sel_pool
                      ? {{(lfip_pkg::APB_DW - lfip_pkg::CFG_W){1'b0}}, w_pool_size}
                      : '0;

    lfip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_cfg_wr (w_cfg_wr),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    lfip_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .LINK_W      (LINK_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_wr        (w_cfg_wr),
        .i_cfg_data      (pwdata[lfip_pkg::CFG_W-1:0]),
        .i_index         (i_index),
        .o_pool_size     (w_pool_size),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_count    (o_free_count)
    );

endmodule

// ===== design/lfip_checker.sv =====
// Port-level assertions for the linked free index pool, bound to the top level.
module lfip_checker #(
    parameter int MAX_ENTRIES = 1024
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            i_cmd,
    input logic                            o_valid,
    input logic                            i_stall,
    input lfip_pkg::t_status               o_status,
    input logic [$clog2(MAX_ENTRIES)-1:0]  o_granted_index,
    input logic [lfip_pkg::CNT_W-1:0]      o_free_count,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic                            pready,
    input logic [lfip_pkg::APB_AW-1:0]     paddr
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_granted_index) && $stable(o_free_count))
        else $error("stalled output word changed");

    a_push_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_cmd == lfip_pkg::CMD_PUSH |=> o_valid)
        else $error("push word not presented in the next cycle");

    a_rebuild_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[2] == lfip_pkg::REG_POOL_SIZE
            |=> o_stall)
        else $error("input not stalled during chain rebuild");

    a_word_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall) || $past(i_valid && !o_stall, 2))
        else $error("output word without an accepted item");

endmodule

bind linked_free_index_pool lfip_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_lfip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_cmd           (i_cmd),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_granted_index (o_granted_index),
    .o_free_count    (o_free_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr)
);

// ===== tb/tb.sv =====
// Self-checking testbench for linked_free_index_pool: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_ENTRIES    = 1024;
    localparam int IDX_W          = $clog2(MAX_ENTRIES);
    localparam int CNT_W          = lfip_pkg::CNT_W;
    localparam int CFG_W          = lfip_pkg::CFG_W;
    localparam int APB_AW         = lfip_pkg::APB_AW;
    localparam int APB_DW         = lfip_pkg::APB_DW;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int TAIL_CYCLES    = 16;

    localparam logic [CNT_W-1:0]  END_MARK       = CNT_W'(MAX_ENTRIES);
    localparam logic [APB_AW-1:0] POOL_SIZE_ADDR = APB_AW'({lfip_pkg::REG_POOL_SIZE, 2'b00});

    typedef struct packed {
        lfip_pkg::t_status status;
        logic [IDX_W-1:0]  granted;
        logic [CNT_W-1:0]  free_count;
    } t_pool_result;

    typedef enum logic {
        ROW_CFG,
        ROW_OP
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [CFG_W-1:0]  size;
        bit                typed;
        t_pool_result      want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_cmd;
    logic [IDX_W-1:0]    i_index;
    logic                o_valid;
    logic                i_stall;
    lfip_pkg::t_status   o_status;
    logic [IDX_W-1:0]    o_granted_index;
    logic [CNT_W-1:0]    o_free_count;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    linked_free_index_pool #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_index(i_index),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_granted_index(o_granted_index),
        .o_free_count(o_free_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    logic [CNT_W-1:0]  link_mem [MAX_ENTRIES];
    logic [CNT_W-1:0]  head_idx;
    logic [CNT_W-1:0]  free_total;
    logic [CFG_W-1:0]  pool_size_reg;

    t_pool_result      owed_results [$];
    logic [IDX_W-1:0]  allocated_ids [$];

    int  fail_count;
    int  quiet_cycles;
    bit  sender_calm;
    bit  recv_calm;
    int  n_pops;
    int  n_pushes;
    int  n_empty;
    int  n_refused;
    int  n_sizes;
    int  peak_free;

    t_dir_row dir_rows [0:29] = '{
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1023}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd1,    11'd1022}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd1023, 11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1023}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd1023, 11'd1022}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd0,    11'd0,    1'b0, '0},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd777,  11'd0,    1'b0, '0},
        '{ROW_CFG, lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b0, '0},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd1023, 11'd0,    1'b1,
          '{lfip_pkg::STATUS_EMPTY, 10'd0,    11'd0}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_RANGE, 10'd0,    11'd0}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd1023, 11'd0,    1'b1,
          '{lfip_pkg::STATUS_RANGE, 10'd0,    11'd0}},
        '{ROW_CFG, lfip_pkg::CMD_POP,  10'd0,    11'd1,    1'b0, '0},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd0}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_EMPTY, 10'd0,    11'd0}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd1,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_RANGE, 10'd0,    11'd0}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd2}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd0}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd0}},
        '{ROW_CFG, lfip_pkg::CMD_POP,  10'd0,    11'd2047, 1'b0, '0},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd1023, 11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1025}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd1023, 11'd1024}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1023}},
        '{ROW_CFG, lfip_pkg::CMD_POP,  10'd0,    11'd2,    1'b0, '0},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd2,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_RANGE, 10'd0,    11'd1}},
        '{ROW_OP,  lfip_pkg::CMD_PUSH, 10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd2}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd0,    11'd1}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_OK,    10'd1,    11'd0}},
        '{ROW_OP,  lfip_pkg::CMD_POP,  10'd0,    11'd0,    1'b1,
          '{lfip_pkg::STATUS_EMPTY, 10'd0,    11'd0}}
    };

    function automatic logic [CNT_W-1:0] active_size();
        return (pool_size_reg > CFG_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : pool_size_reg;
    endfunction

    function automatic void rebuild_free_chain();
        logic [CNT_W-1:0] p;
        p = active_size();
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            link_mem[IDX_W'(i)] = (i + 1 < int'(p)) ? CNT_W'(i + 1) : END_MARK;
        end
        head_idx   = (p == '0) ? END_MARK : '0;
        free_total = p;
    endfunction

    function automatic t_pool_result apply_pool_op(logic cmd, logic [IDX_W-1:0] idx);
        t_pool_result r;
        r = '{lfip_pkg::STATUS_OK, '0, '0};
        if (cmd == lfip_pkg::CMD_POP) begin
            if (head_idx >= END_MARK) begin
                r.status = lfip_pkg::STATUS_EMPTY;
            end else begin
                r.granted = IDX_W'(head_idx);
                head_idx  = link_mem[head_idx[IDX_W-1:0]];
                if (free_total > '0) free_total = free_total - CNT_W'(1);
            end
        end else begin
            if (CNT_W'(idx) >= active_size()) begin
                r.status = lfip_pkg::STATUS_RANGE;
            end else begin
                link_mem[idx] = head_idx;
                head_idx      = CNT_W'(idx);
                if (free_total < lfip_pkg::COUNT_MAX) free_total = free_total + CNT_W'(1);
            end
        end
        r.free_count = free_total;
        return r;
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_pool_size(input logic [CFG_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_SIZE_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        pool_size_reg = value;
        rebuild_free_chain();
        allocated_ids.delete();
        n_sizes++;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DW'(value)) begin
            fail_count++;
            $error("pool_size: expected %0d, got %0d", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_op(input logic cmd, input logic [IDX_W-1:0] idx,
                           input bit typed, input t_pool_result want);
        int gap;
        t_pool_result got;
        if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : int'($urandom_range(0, 11));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_index <= idx;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        got = apply_pool_op(cmd, idx);
        owed_results.push_back(typed ? want : got);
        if (cmd == lfip_pkg::CMD_POP) n_pops++;
        else n_pushes++;
        if (got.status == lfip_pkg::STATUS_EMPTY) n_empty++;
        if (got.status == lfip_pkg::STATUS_RANGE) n_refused++;
        if (cmd == lfip_pkg::CMD_POP && got.status == lfip_pkg::STATUS_OK) begin
            allocated_ids.push_back(got.granted);
        end
        if (int'(got.free_count) > peak_free) peak_free = int'(got.free_count);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] size, input int n_ops, input bit flood);
        int pop_pct;
        int pick;
        int j;
        logic [CNT_W-1:0] p;
        logic cmd;
        logic [IDX_W-1:0] idx;
        write_pool_size(size);
        p = active_size();
        pop_pct = 50;
        for (int k = 0; k < n_ops; k++) begin
            if (k % 32 == 0) pop_pct = flood ? 2 : int'($urandom_range(15, 85));
            if ($urandom_range(0, 119) == 0) wait_drained();
            idx = IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
            cmd = ($urandom_range(0, 99) < pop_pct) ? lfip_pkg::CMD_POP : lfip_pkg::CMD_PUSH;
            if (cmd == lfip_pkg::CMD_PUSH) begin
                pick = flood ? 70 : int'($urandom_range(0, 99));
                if (pick < 65 && allocated_ids.size() > 0) begin
                    j   = int'($urandom_range(0, allocated_ids.size() - 1));
                    idx = allocated_ids[j];
                    allocated_ids.delete(j);
                end else if (pick < 80 && p > '0) begin
                    idx = IDX_W'($urandom_range(0, p - 1));
                end else if (pick < 92 && p < CNT_W'(MAX_ENTRIES)) begin
                    idx = IDX_W'($urandom_range(p, MAX_ENTRIES - 1));
                end
            end
            send_op(cmd, idx, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int wait_n;
        t_pool_result want;
        i_stall <= 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
            wait_n = recv_calm ? 0 : int'($urandom_range(0, 11));
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (owed_results.size() == 0) begin
                fail_count++;
                $error("result word with nothing expected: status %0d granted %0d free %0d",
                       o_status, o_granted_index, o_free_count);
            end else begin
                want = owed_results.pop_front();
                if (o_status !== want.status) begin
                    fail_count++;
                    $error("status: expected %0d, got %0d", want.status, o_status);
                end
                if (o_granted_index !== want.granted) begin
                    fail_count++;
                    $error("granted_index: expected %0d, got %0d", want.granted, o_granted_index);
                end
                if (o_free_count !== want.free_count) begin
                    fail_count++;
                    $error("free_count: expected %0d, got %0d", want.free_count, o_free_count);
                end
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        fail_count   = 0;
        sender_calm  = 1'b0;
        recv_calm    = 1'b0;
        n_pops       = 0;
        n_pushes     = 0;
        n_empty      = 0;
        n_refused    = 0;
        n_sizes      = 0;
        peak_free    = 0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_cmd    <= lfip_pkg::CMD_POP;
        i_index  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        pool_size_reg = lfip_pkg::POOL_RESET;
        rebuild_free_chain();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_pool_size(dir_rows[r].size);
            end else begin
                send_op(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        run_phase(11'd3, 120, 1'b0);
        run_phase(11'd0, 40, 1'b0);
        run_phase(11'd64, 150, 1'b0);
        run_phase(11'd1500, 1150, 1'b1);
        run_phase(11'd1, 90, 1'b0);
        run_phase(11'd700, 150, 1'b0);
        run_phase(11'd16, 150, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            fail_count++;
            $error("%0d expected result words never arrived", owed_results.size());
        end
        $display("Ran %0d pops and %0d pushes across %0d pool_size settings.",
                 n_pops, n_pushes, n_sizes);
        $display("Saw %0d empty pops, %0d refused pushes, peak free count %0d.",
                 n_empty, n_refused, peak_free);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
